[src/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check outside reset (disabled while rst_ni is low)
`define NTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check at every edge, reset included
`define NTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

[src/ntt_pkg.sv]
package ntt_pkg;

  typedef struct packed {
    logic        cmd;
    logic        direction;
    logic [1:0]  protocol;
    logic [7:0]  msg_type;
    logic        flag_syn;
    logic        flag_fin;
    logic        flag_ack;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] icmp_id;
  } ntt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] out_icmp_id;
    logic [4:0]  expired_count;
  } ntt_res_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic decide;
    logic psrch_step;
    logic apply;
    logic age_step;
    logic out_load;
  } ntt_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic scan_last;
    logic alloc_go;
    logic port_found;
    logic out_free;
  } ntt_sts_t;

  localparam logic [2:0] STS_XLATE  = 3'd0;
  localparam logic [2:0] STS_PASS   = 3'd1;
  localparam logic [2:0] STS_NOMAP  = 3'd2;
  localparam logic [2:0] STS_FULL   = 3'd3;
  localparam logic [2:0] STS_UNSUP  = 3'd4;

  localparam logic       CMD_TICK   = 1'b1;
  localparam logic       DIR_OUT    = 1'b0;
  localparam logic       DIR_IN     = 1'b1;
  localparam logic [1:0] PROTO_ICMP = 2'd0;
  localparam logic [1:0] PROTO_TCP  = 2'd1;
  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REP = 8'd0;

  localparam logic [2:0] CS_ICMP   = 3'd0;
  localparam logic [2:0] CS_SYN1   = 3'd1;
  localparam logic [2:0] CS_SYN2   = 3'd2;
  localparam logic [2:0] CS_EST    = 3'd3;
  localparam logic [2:0] CS_FIN1   = 3'd4;
  localparam logic [2:0] CS_FIN2   = 3'd5;
  localparam logic [2:0] CS_CLOSED = 3'd6;
  localparam logic [2:0] CS_UNSOL  = 3'd7;

  localparam logic [15:0] PORT_LOW  = 16'd1024;
  localparam logic [15:0] PORT_HIGH = 16'd65535;

  localparam logic [2:0] CFG_EXT_IP    = 3'd0;
  localparam logic [2:0] CFG_ICMP_TO   = 3'd1;
  localparam logic [2:0] CFG_EST_TO    = 3'd2;
  localparam logic [2:0] CFG_TRANS_TO  = 3'd3;
  localparam logic [2:0] CFG_UNSOL_TO  = 3'd4;

  localparam logic [31:0] RST_EXT_IP   = 32'd3091753181;
  localparam logic [7:0]  MIN_ICMP_TO  = 8'd60;
  localparam logic [15:0] MIN_EST_TO   = 16'd7440;
  localparam logic [15:0] MIN_TRANS_TO = 16'd300;
  localparam logic [15:0] RST_UNSOL_TO = 16'd6;
  localparam logic [15:0] MIN_UNSOL_TO = 16'd1;

  localparam logic [4:0]  EXP_MAX = 5'd31;

endpackage

[src/ntt_ctrl.sv]
module ntt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ntt_pkg::ntt_sts_t sts_i,
  output ntt_pkg::ntt_cmd_t cmd_o
);
  import ntt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_PSRCH  = 7'b0001000,
    S_APPLY  = 7'b0010000,
    S_AGE    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_tick ? S_AGE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.alloc_go ? S_PSRCH : S_APPLY;
      end
      S_PSRCH: begin
        cmd_o.psrch_step = 1'b1;
        if (sts_i.port_found) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_DONE;
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/ntt_datapath.sv]
`include "assert_macros.svh"

module ntt_datapath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntt_pkg::ntt_req_t in_req_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output ntt_pkg::ntt_res_t out_res_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  ntt_pkg::ntt_cmd_t cmd_i,
  output ntt_pkg::ntt_sts_t sts_o
);
  import ntt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [31:0] ext_ip_q;
  logic [7:0]  icmp_to_q;
  logic [15:0] est_to_q, trans_to_q, unsol_to_q;

  logic        valid_q [TABLE_ENTRIES];
  logic        tcp_q   [TABLE_ENTRIES];
  logic [31:0] ip_q    [TABLE_ENTRIES];
  logic [15:0] iport_q [TABLE_ENTRIES];
  logic [15:0] xport_q [TABLE_ENTRIES];
  logic [2:0]  cs_q    [TABLE_ENTRIES];
  logic [15:0] idle_q  [TABLE_ENTRIES];

  ntt_req_t    req_q;
  ntt_res_t    res_q, res_d, out_q, tick_res;
  logic        out_valid_q;
  logic [IDX_W-1:0] scan_q, e_q, slot_q;
  logic [IDX_W-1:0] int1_q, int2_q, ext1_q, peer_q, free_q;
  logic        int1_f_q, int2_f_q, ext1_f_q, peer_f_q, free_f_q, e_f_q, full_q;
  logic [15:0] cand_q, cursor_q;
  logic [4:0]  exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_ip_q   <= RST_EXT_IP;
      icmp_to_q  <= MIN_ICMP_TO;
      est_to_q   <= MIN_EST_TO;
      trans_to_q <= MIN_TRANS_TO;
      unsol_to_q <= RST_UNSOL_TO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXT_IP:   ext_ip_q <= cfg_data_i;
        CFG_ICMP_TO:  icmp_to_q <= (cfg_data_i[7:0] < MIN_ICMP_TO) ? MIN_ICMP_TO
                                                                    : cfg_data_i[7:0];
        CFG_EST_TO:   est_to_q <= (cfg_data_i[15:0] < MIN_EST_TO) ? MIN_EST_TO
                                                                   : cfg_data_i[15:0];
        CFG_TRANS_TO: trans_to_q <= (cfg_data_i[15:0] < MIN_TRANS_TO) ? MIN_TRANS_TO
                                                                       : cfg_data_i[15:0];
        CFG_UNSOL_TO: unsol_to_q <= (cfg_data_i[15:0] < MIN_UNSOL_TO) ? MIN_UNSOL_TO
                                                                       : cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [IDX_W-1:0] rd_addr;
  logic        r_v, r_tcp;
  logic [31:0] r_ip;
  logic [15:0] r_iport, r_xport, r_idle;
  logic [2:0]  r_cs;

  assign rd_addr = cmd_i.apply ? e_q : scan_q;
  assign r_v     = valid_q[rd_addr];
  assign r_tcp   = tcp_q[rd_addr];
  assign r_ip    = ip_q[rd_addr];
  assign r_iport = iport_q[rd_addr];
  assign r_xport = xport_q[rd_addr];
  assign r_cs    = cs_q[rd_addr];
  assign r_idle  = idle_q[rd_addr];

  logic        is_icmp, is_tcp, icmp_out, icmp_in, tcp_out, tcp_in, same_pair;
  logic [15:0] int_key, ext_key;

  assign is_icmp   = (req_q.protocol == PROTO_ICMP);
  assign is_tcp    = (req_q.protocol == PROTO_TCP);
  assign icmp_out  = is_icmp && req_q.direction == DIR_OUT && req_q.msg_type == ICMP_ECHO_REQ;
  assign icmp_in   = is_icmp && req_q.direction == DIR_IN && req_q.msg_type == ICMP_ECHO_REP;
  assign tcp_out   = is_tcp && req_q.direction == DIR_OUT;
  assign tcp_in    = is_tcp && req_q.direction == DIR_IN;
  assign int_key   = is_icmp ? req_q.icmp_id : req_q.src_port;
  assign ext_key   = is_icmp ? req_q.icmp_id : req_q.dst_port;
  assign same_pair = (req_q.dst_ip == req_q.src_ip) && (req_q.dst_port == req_q.src_port);

  logic hit_int, hit_ext, hit_peer;
  assign hit_int  = r_v && (r_tcp == is_tcp) && r_ip == req_q.src_ip && r_iport == int_key;
  assign hit_ext  = r_v && (r_tcp == is_tcp) && r_xport == ext_key;
  assign hit_peer = r_v && r_tcp && r_ip == req_q.dst_ip && r_iport == req_q.dst_port;

  logic             free_old, eint_f, slot_f, need_alloc;
  logic [IDX_W-1:0] eint, slot_idx;

  assign free_old = tcp_out && req_q.flag_syn && peer_f_q;
  assign eint_f   = (free_old && same_pair) ? int2_f_q : int1_f_q;
  assign eint     = (free_old && same_pair) ? int2_q : int1_q;
  assign slot_f   = free_f_q || free_old;
  assign slot_idx = (free_old && !(free_f_q && free_q < peer_q)) ? peer_q : free_q;
  assign need_alloc = (icmp_out && !int1_f_q) || (tcp_out && req_q.flag_syn && !eint_f)
                   || (tcp_in && req_q.flag_syn && !ext1_f_q);

  logic        port_hit, port_found;
  logic [15:0] cand_nxt, cursor_nxt;
  logic [2:0]  alloc_cs;

  assign port_hit   = r_v && (r_xport == cand_q);
  assign port_found = !port_hit && scan_q == LAST;
  assign cand_nxt   = (cand_q == PORT_HIGH) ? PORT_LOW : cand_q + 16'd1;
  assign cursor_nxt = cand_nxt;
  assign alloc_cs   = is_icmp ? CS_ICMP : (req_q.direction == DIR_IN ? CS_UNSOL : CS_SYN1);

  logic [15:0] idle_inc, tmo;
  logic        expire;
  logic [4:0]  exp_nxt;

  assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
  always_comb begin
    if (!r_tcp)               tmo = {8'd0, icmp_to_q};
    else if (r_cs == CS_UNSOL) tmo = unsol_to_q;
    else if (r_cs == CS_EST)   tmo = est_to_q;
    else                       tmo = trans_to_q;
  end
  assign expire  = r_v && (idle_inc > tmo);
  assign exp_nxt = (expire && exp_q != EXP_MAX) ? exp_q + 5'd1 : exp_q;

  always_comb begin
    tick_res               = '0;
    tick_res.status        = STS_XLATE;
    tick_res.expired_count = exp_nxt;
  end

  logic [2:0] cs_new;
  logic       cs_we;

  always_comb begin
    res_d               = '0;
    res_d.status        = STS_PASS;
    res_d.out_src_ip    = req_q.src_ip;
    res_d.out_dst_ip    = req_q.dst_ip;
    res_d.out_src_port  = req_q.src_port;
    res_d.out_dst_port  = req_q.dst_port;
    res_d.out_icmp_id   = req_q.icmp_id;
    cs_new              = r_cs;
    cs_we               = 1'b0;
    if (!is_icmp && !is_tcp) begin
      res_d.status = STS_UNSUP;
    end else if (icmp_out) begin
      if (e_f_q) begin
        res_d.out_icmp_id = r_xport;
        res_d.out_src_ip  = ext_ip_q;
        res_d.status      = STS_XLATE;
      end else begin
        res_d.status = STS_FULL;
      end
    end else if (icmp_in) begin
      if (e_f_q) begin
        res_d.out_icmp_id = r_iport;
        res_d.out_dst_ip  = r_ip;
        res_d.status      = STS_XLATE;
      end else begin
        res_d.status = STS_NOMAP;
      end
    end else if (tcp_out) begin
      if (!e_f_q) begin
        res_d.status = req_q.flag_syn ? STS_FULL : STS_NOMAP;
      end else begin
        cs_we = 1'b1;
        if (req_q.flag_syn) begin
          cs_new = CS_SYN1;
        end else if (req_q.flag_fin) begin
          if (r_cs == CS_FIN1)     cs_new = CS_FIN2;
          else if (r_cs == CS_EST) cs_new = CS_FIN1;
        end else if (req_q.flag_ack) begin
          if (r_cs == CS_SYN2)      cs_new = CS_EST;
          else if (r_cs == CS_FIN2) cs_new = CS_CLOSED;
        end
        res_d.out_src_port = r_xport;
        res_d.out_src_ip   = ext_ip_q;
        res_d.status       = STS_XLATE;
      end
    end else if (tcp_in) begin
      if (!e_f_q) begin
        res_d.status = (req_q.flag_syn && full_q) ? STS_FULL : STS_NOMAP;
      end else if (req_q.flag_syn && r_cs != CS_SYN1) begin
        res_d.status = STS_NOMAP;
      end else begin
        cs_we = 1'b1;
        if (req_q.flag_syn) begin
          cs_new = CS_SYN2;
        end else if (req_q.flag_fin) begin
          if (r_cs == CS_FIN1)     cs_new = CS_FIN2;
          else if (r_cs == CS_EST) cs_new = CS_FIN1;
        end else if (req_q.flag_ack) begin
          if (r_cs == CS_FIN2) cs_new = CS_CLOSED;
        end
        res_d.out_dst_port = r_iport;
        res_d.out_dst_ip   = r_ip;
        res_d.status       = STS_XLATE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_q[i] <= 1'b0;
    end else if (cmd_i.decide && free_old) begin
      valid_q[peer_q] <= 1'b0;
    end else if (cmd_i.psrch_step && port_found) begin
      valid_q[slot_q] <= 1'b1;
    end else if (cmd_i.age_step && expire) begin
      valid_q[scan_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.psrch_step && port_found) begin
      tcp_q[slot_q]   <= is_tcp;
      ip_q[slot_q]    <= req_q.src_ip;
      iport_q[slot_q] <= int_key;
      xport_q[slot_q] <= cand_q;
      cs_q[slot_q]    <= alloc_cs;
      idle_q[slot_q]  <= '0;
    end else if (cmd_i.apply) begin
      if (cs_we) cs_q[e_q] <= cs_new;
      if (res_d.status == STS_XLATE && e_f_q) idle_q[e_q] <= '0;
    end else if (cmd_i.age_step && r_v) begin
      idle_q[scan_q] <= idle_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      cursor_q <= PORT_LOW;
      int1_f_q <= 1'b0;
      int2_f_q <= 1'b0;
      ext1_f_q <= 1'b0;
      peer_f_q <= 1'b0;
      free_f_q <= 1'b0;
      e_f_q    <= 1'b0;
      full_q   <= 1'b0;
      exp_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_q   <= '0;
        int1_f_q <= 1'b0;
        int2_f_q <= 1'b0;
        ext1_f_q <= 1'b0;
        peer_f_q <= 1'b0;
        free_f_q <= 1'b0;
        exp_q    <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
        if (hit_int && !int1_f_q) begin
          int1_f_q <= 1'b1;
          int1_q   <= scan_q;
        end else if (hit_int && !int2_f_q) begin
          int2_f_q <= 1'b1;
          int2_q   <= scan_q;
        end
        if (hit_ext && !ext1_f_q) begin
          ext1_f_q <= 1'b1;
          ext1_q   <= scan_q;
        end
        if (hit_peer && !peer_f_q) begin
          peer_f_q <= 1'b1;
          peer_q   <= scan_q;
        end
        if (!r_v && !free_f_q) begin
          free_f_q <= 1'b1;
          free_q   <= scan_q;
        end
      end
      if (cmd_i.decide) begin
        scan_q <= '0;
        cand_q <= cursor_q;
        slot_q <= slot_idx;
        full_q <= need_alloc && !slot_f;
        if (req_q.direction == DIR_OUT) begin
          e_f_q <= eint_f;
          e_q   <= eint;
        end else begin
          e_f_q <= ext1_f_q;
          e_q   <= ext1_q;
        end
      end
      if (cmd_i.psrch_step) begin
        if (port_hit) begin
          cand_q <= cand_nxt;
          scan_q <= '0;
        end else if (port_found) begin
          cursor_q <= cursor_nxt;
          if (req_q.direction == DIR_OUT) begin
            e_f_q <= 1'b1;
            e_q   <= slot_q;
          end
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (cmd_i.age_step) begin
        scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
        exp_q  <= exp_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.apply) res_q <= res_d;
    if (cmd_i.age_step && scan_q == LAST) res_q <= tick_res;
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_res_o         = out_q;
  assign sts_o.in_tick     = (in_req_i.cmd == CMD_TICK);
  assign sts_o.scan_last   = (scan_q == LAST);
  assign sts_o.alloc_go    = need_alloc && slot_f;
  assign sts_o.port_found  = port_found;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  `NTT_ASSERT(a_out_load_valid, cmd_i.out_load |=> out_valid_q, "result load lost")
  `NTT_ASSERT(a_peer_freed, (cmd_i.decide && free_old) |=> !valid_q[peer_q],
              "pending peer mapping not freed")
  `NTT_ASSERT(a_cursor_range, cursor_q >= PORT_LOW, "port cursor below range")
  `NTT_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !out_valid_q, "result pending after reset")

endmodule

[src/nat_translation_table_top.sv]
// NAPT port translation table.
// Request channel: in_valid_i / in_stall_o with in_req_i, either a parsed
// packet header or a one-second tick. Result channel: out_valid_o /
// out_stall_i with out_res_o, exactly one result per request, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 external address, 1..4 timeouts); write only while idle.
// A packet scans the table once, then passes a decide step and an apply
// step, and its result is handed off to the output register. A packet that
// opens a mapping adds a port search, which scans the table anew for each
// candidate port tried, up to TABLE_ENTRIES candidates. A tick instead ages
// every table entry once before its result is handed off.
// The table has one read port, shared by scan, port search, aging and apply.
// One request is worked on at a time; the next request is taken once the
// result sits in the output register, which holds while out_stall_i is high.
// Reset clears all mappings, loads the default registers and sets the port
// cursor to 1024; no result is pending after reset.
module nat_translation_table_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ntt_pkg::ntt_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ntt_pkg::ntt_res_t out_res_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import ntt_pkg::*;

  ntt_cmd_t cmd;
  ntt_sts_t sts;

  ntt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ntt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
